@@ src/spts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the string pair table search block.
// No dependencies; every other file but spts_table_mem imports this package.
package spts_pkg;

	// Request operation codes
	localparam logic [1:0] OP_TABLE_WRITE = 2'd0;
	localparam logic [1:0] OP_KEY_APPEND  = 2'd1;
	localparam logic [1:0] OP_SEARCH      = 2'd2;

	// Search modes
	localparam logic [1:0] MODE_EXACT   = 2'd0;
	localparam logic [1:0] MODE_PREFIX  = 2'd1;
	localparam logic [1:0] MODE_INVERSE = 2'd2;

	// Fixed field widths
	localparam int POS_W = 12;
	localparam int LEN_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OFFSET,
		ST_SKIP,
		ST_MATCH
	} walk_state_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   partner_position;
		logic [POS_W-1:0]   next_start;
		logic [LEN_W-1:0]   matched_length;
		logic               overrun;
	} result_t;

endpackage

@@ src/spts_table_mem.sv @@
`timescale 1ns / 1ps
// Table byte memory: one write port, one read port with registered data.
// Standalone; no package dependency.
module spts_table_mem #(
	parameter int TABLE_BYTES = 4096,
	localparam int AW = $clog2(TABLE_BYTES)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [TABLE_BYTES];
	logic [7:0] rd_data_q;

	// Write one table byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one byte a cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/spts_key_buf.sv @@
`timescale 1ns / 1ps
// Key buffer memory with its length register and append logic.
// Depends on spts_pkg for the length width.
module spts_key_buf import spts_pkg::*; #(
	parameter int KEY_BYTES = 256,
	localparam int KW = $clog2(KEY_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             app_en,
	input  logic             app_first,
	input  logic [7:0]       app_data,
	input  logic [KW-1:0]    rd_idx,
	output logic [7:0]       rd_data,
	output logic [LEN_W-1:0] key_length
);

	localparam logic [LEN_W-1:0] KEY_CAP = LEN_W'(KEY_BYTES - 1);

	logic [7:0]       mem_q [KEY_BYTES];
	logic [7:0]       rd_data_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_base;
	logic             store;

	// Clear first if asked, then drop zero bytes and bytes past capacity
	always_comb begin
		len_base = app_first ? '0 : len_q;
		store    = (app_data != 8'd0) && (len_base < KEY_CAP);
	end

	// Track key length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (app_en) begin
			len_q <= store ? LEN_W'(len_base + 1'b1) : len_base;
		end
	end

	// Store appended byte
	always_ff @(posedge clk) begin
		if (app_en && store) begin
			mem_q[len_base[KW-1:0]] <= app_data;
		end
	end

	// Read one key byte a cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_idx];
	end

	assign rd_data    = rd_data_q;
	assign key_length = len_q;

endmodule

@@ src/spts_walker.sv @@
`timescale 1ns / 1ps
// Search sequencer: walks table records one byte a cycle and registers the result.
// Depends on spts_pkg; drives the read ports of the table memory and key buffer.
module spts_walker import spts_pkg::*; #(
	parameter int TABLE_BYTES = 4096,
	parameter int KEY_BYTES = 256,
	localparam int AW = $clog2(TABLE_BYTES),
	localparam int KW = $clog2(KEY_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [1:0]       go_mode,
	input  logic [POS_W-1:0] go_start,
	output logic             busy,
	output logic [AW-1:0]    t_rd_addr,
	input  logic [7:0]       t_rd_data,
	output logic [KW-1:0]    k_rd_idx,
	input  logic [7:0]       k_rd_data,
	input  logic [LEN_W-1:0] key_length,
	output logic             done,
	output result_t          res
);

	localparam int PW_RAW = $clog2(TABLE_BYTES + 256) + 1;
	localparam int PW = (PW_RAW > 13) ? PW_RAW : 13;
	localparam logic [PW-1:0] TB = PW'(TABLE_BYTES);

	walk_state_t      state_q, state_d;
	logic [PW-1:0]    pos_q, pos_d;
	logic [PW-1:0]    nxt_q, nxt_d;
	logic [PW-1:0]    p_q, p_d;
	logic [LEN_W-1:0] i_q, i_d;
	logic [1:0]       mode_q, mode_d;
	logic [PW-1:0]    rd_pos;
	logic [LEN_W-1:0] rd_i;
	logic [PW-1:0]    p1;
	logic [PW-1:0]    start_ext;
	logic             brk;
	logic             fin;
	result_t          fin_res;
	logic             done_q;
	result_t          res_q;

	// Next state, read addresses and result
	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		nxt_d     = nxt_q;
		p_d       = p_q;
		i_d       = i_q;
		mode_d    = mode_q;
		rd_pos    = pos_q;
		rd_i      = i_q;
		fin       = 1'b0;
		fin_res   = '0;
		start_ext = PW'(go_start);
		p1        = PW'(p_q + 1'b1);
		brk       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					mode_d = go_mode;
					pos_d  = start_ext;
					rd_pos = start_ext;
					if (start_ext >= TB) begin
						fin             = 1'b1;
						fin_res.overrun = 1'b1;
					end else begin
						state_d = ST_OFFSET;
					end
				end
			end
			ST_OFFSET: begin
				p1 = PW'(pos_q + 1'b1);
				if (t_rd_data == 8'd0) begin
					fin                = 1'b1;
					fin_res.next_start = pos_q[POS_W-1:0];
					state_d            = ST_IDLE;
				end else begin
					nxt_d  = PW'(pos_q + {{(PW-8){1'b0}}, t_rd_data});
					p_d    = p1;
					i_d    = '0;
					rd_pos = p1;
					rd_i   = '0;
					if (p1 >= TB) begin
						fin             = 1'b1;
						fin_res.overrun = 1'b1;
						state_d         = ST_IDLE;
					end else if (mode_q == MODE_INVERSE) begin
						state_d = ST_SKIP;
					end else begin
						state_d = ST_MATCH;
					end
				end
			end
			ST_SKIP: begin
				// Step over the first string up to and past its terminator
				p_d    = p1;
				i_d    = '0;
				rd_pos = p1;
				rd_i   = '0;
				if (p1 >= TB) begin
					fin             = 1'b1;
					fin_res.overrun = 1'b1;
					state_d         = ST_IDLE;
				end else if (t_rd_data == 8'd0) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				brk = (t_rd_data == 8'd0) || (i_q >= key_length) || (t_rd_data != k_rd_data);
				if (!brk) begin
					p_d    = p1;
					i_d    = LEN_W'(i_q + 1'b1);
					rd_pos = p1;
					rd_i   = LEN_W'(i_q + 1'b1);
					if (p1 >= TB) begin
						fin             = 1'b1;
						fin_res.overrun = 1'b1;
						state_d         = ST_IDLE;
					end
				end else if (t_rd_data == 8'd0 &&
					(mode_q != MODE_EXACT || i_q == key_length)) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
					if (mode_q == MODE_INVERSE) begin
						fin_res.found            = 1'b1;
						fin_res.partner_position = POS_W'(pos_q + 1'b1);
						fin_res.next_start       = nxt_q[POS_W-1:0];
						fin_res.matched_length   = i_q;
					end else if (p1 >= TB) begin
						fin_res.overrun = 1'b1;
					end else begin
						fin_res.found            = 1'b1;
						fin_res.partner_position = p1[POS_W-1:0];
						fin_res.next_start       = nxt_q[POS_W-1:0];
						fin_res.matched_length   = i_q;
					end
				end else begin
					// Advance to the next record
					pos_d  = nxt_q;
					rd_pos = nxt_q;
					if (nxt_q >= TB) begin
						fin             = 1'b1;
						fin_res.overrun = 1'b1;
						state_d         = ST_IDLE;
					end else begin
						state_d = ST_OFFSET;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	// Hold walk positions and the result
	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		nxt_q  <= nxt_d;
		p_q    <= p_d;
		i_q    <= i_d;
		mode_q <= mode_d;
		if (fin) begin
			res_q <= fin_res;
		end
	end

	assign t_rd_addr = rd_pos[AW-1:0];
	assign k_rd_idx  = rd_i[KW-1:0];
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_no_found_and_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res.found && res.overrun))
		else $error("found and overrun set together");
	a_overrun_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.overrun |-> res.partner_position == '0 && res.next_start == '0 &&
			res.matched_length == '0)
		else $error("overrun result carries nonzero fields");
	a_match_within_key: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.found |-> res.matched_length <= key_length)
		else $error("matched length exceeds key length");
	a_search_progress: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && go |=> busy || done)
		else $error("accepted search neither walks nor finishes");
	a_not_found_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.found |-> res.matched_length == '0)
		else $error("not-found result carries a matched length");
`endif

endmodule

@@ src/string_pair_table_search.sv @@
`timescale 1ns / 1ps
// Top level of the string pair table search: table memory, key buffer, walker.
// Depends on spts_pkg, spts_table_mem, spts_key_buf and spts_walker.
//
//   channel   handshake          payload
//   request   start / busy       op, table_address, byte_value, key_first,
//                                search_mode, start_position
//   result    done (strobe)      found, partner_position, next_start,
//                                matched_length, overrun
//
// Table writes and key appends leave busy low.
// A search steps through each record header, then in inverse mode the skipped
// first-string bytes, then the compared bytes, each read through the single table
// read port; the result strobe follows in the cycle after the last read.
// Reset clears the walker and the key length; memory contents are kept.
// Done is high for a single cycle, since the receiver cannot stall; the result holds.
module string_pair_table_search import spts_pkg::*; #(
	parameter int TABLE_BYTES = 4096,
	parameter int KEY_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       op,
	input  logic [POS_W-1:0] table_address,
	input  logic [7:0]       byte_value,
	input  logic             key_first,
	input  logic [1:0]       search_mode,
	input  logic [POS_W-1:0] start_position,
	output logic             done,
	output logic             found,
	output logic [POS_W-1:0] partner_position,
	output logic [POS_W-1:0] next_start,
	output logic [LEN_W-1:0] matched_length,
	output logic             overrun
);

	localparam int AW = $clog2(TABLE_BYTES);
	localparam int KW = $clog2(KEY_BYTES);

	logic             accept;
	logic             tbl_wr;
	logic             key_app;
	logic             go;
	logic [AW-1:0]    t_rd_addr;
	logic [7:0]       t_rd_data;
	logic [KW-1:0]    k_rd_idx;
	logic [7:0]       k_rd_data;
	logic [LEN_W-1:0] key_length;
	result_t          res;

	// Decode the accepted request
	always_comb begin
		accept  = start && !busy;
		tbl_wr  = accept && (op == OP_TABLE_WRITE) && (32'(table_address) < TABLE_BYTES);
		key_app = accept && (op == OP_KEY_APPEND);
		go      = accept && (op == OP_SEARCH) &&
			(search_mode == MODE_EXACT || search_mode == MODE_PREFIX ||
			 search_mode == MODE_INVERSE);
	end

	spts_table_mem #(.TABLE_BYTES(TABLE_BYTES)) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (AW'(table_address)),
		.wr_data (byte_value),
		.rd_addr (t_rd_addr),
		.rd_data (t_rd_data)
	);

	spts_key_buf #(.KEY_BYTES(KEY_BYTES)) u_key (
		.clk        (clk),
		.arst_n     (arst_n),
		.app_en     (key_app),
		.app_first  (key_first),
		.app_data   (byte_value),
		.rd_idx     (k_rd_idx),
		.rd_data    (k_rd_data),
		.key_length (key_length)
	);

	spts_walker #(.TABLE_BYTES(TABLE_BYTES), .KEY_BYTES(KEY_BYTES)) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.go_mode    (search_mode),
		.go_start   (start_position),
		.busy       (busy),
		.t_rd_addr  (t_rd_addr),
		.t_rd_data  (t_rd_data),
		.k_rd_idx   (k_rd_idx),
		.k_rd_data  (k_rd_data),
		.key_length (key_length),
		.done       (done),
		.res        (res)
	);

	assign found            = res.found;
	assign partner_position = res.partner_position;
	assign next_start       = res.next_start;
	assign matched_length   = res.matched_length;
	assign overrun          = res.overrun;

endmodule

@@ sim/tb_string_pair_table_search.sv @@
`timescale 1ns / 1ps
// Self-checking bench for string_pair_table_search: zero-fills the table, runs
// directed record layouts, then random record chains, keys and searches.
// Depends on spts_pkg and the string_pair_table_search RTL.
module tb_string_pair_table_search;
	import spts_pkg::*;

	localparam int TBL_SIZE = 4096;
	localparam int KEY_SIZE = 256;
	localparam int RANDOM_ITEMS = 750;
	localparam int STALL_LIMIT = 100000;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [7:0] CHAR_A = 8'h61;

	typedef struct packed {
		logic [1:0]       op;
		logic [POS_W-1:0] addr;
		logic [7:0]       val;
		logic             first;
		logic [1:0]       mode;
		logic [POS_W-1:0] spos;
	} request_t;

	// Mirror of the table and key; predicts one result per search request with a valid mode
	class lookup_scoreboard;
		logic [7:0] tbl [TBL_SIZE];
		logic [7:0] key [KEY_SIZE];
		int key_len;
		result_t pending_results[$];
		result_t last_prediction;
		int errors, searches, hits, overruns, key_drops;

		function result_t walk_records(logic [1:0] mode, int spos);
			result_t r;
			int pos, nxt, p, i, partner;
			r = '0;
			pos = spos;
			forever begin
				if (pos >= TBL_SIZE)
					break;
				// end marker: report its position
				if (tbl[pos] == 8'd0) begin
					r.next_start = POS_W'(pos);
					return r;
				end
				nxt = pos + int'(tbl[pos]);
				p = pos + 1;
				// inverse mode compares the partner, so skip the first string
				if (mode == MODE_INVERSE) begin
					while (p < TBL_SIZE && tbl[p] != 8'd0)
						p++;
					if (p >= TBL_SIZE)
						break;
					p++;
				end
				// advance while the string follows the key
				i = 0;
				while (p < TBL_SIZE && tbl[p] != 8'd0 && i < key_len && tbl[p] == key[i]) begin
					p++;
					i++;
				end
				if (p >= TBL_SIZE)
					break;
				if (tbl[p] == 8'd0 && (mode != MODE_EXACT || i == key_len)) begin
					partner = (mode == MODE_INVERSE) ? pos + 1 : p + 1;
					if (partner >= TBL_SIZE)
						break;
					r.found = 1'b1;
					r.partner_position = POS_W'(partner);
					r.next_start = POS_W'(nxt);
					r.matched_length = LEN_W'(i);
					return r;
				end
				pos = nxt;
			end
			// walk left the table
			r.overrun = 1'b1;
			return r;
		endfunction

		function void note_request(request_t rq);
			case (rq.op)
				OP_TABLE_WRITE: tbl[rq.addr] = rq.val;
				OP_KEY_APPEND: begin
					if (rq.first)
						key_len = 0;
					// zero bytes are never stored; a full key drops the byte
					if (rq.val != 8'd0) begin
						if (key_len < KEY_SIZE - 1) begin
							key[key_len] = rq.val;
							key_len++;
						end else begin
							key_drops++;
						end
					end
				end
				OP_SEARCH: begin
					if (rq.mode != MODE_UNUSED) begin
						last_prediction = walk_records(rq.mode, int'(rq.spos));
						pending_results.push_back(last_prediction);
						searches++;
						hits += int'(last_prediction.found);
						overruns += int'(last_prediction.overrun);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no search pending: found %0d next_start %0d",
					got.found, got.next_start);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.partner_position !== want.partner_position) begin
				$error("partner_position: expected %0d, got %0d",
					want.partner_position, got.partner_position);
				errors++;
			end
			if (got.next_start !== want.next_start) begin
				$error("next_start: expected %0d, got %0d", want.next_start, got.next_start);
				errors++;
			end
			if (got.matched_length !== want.matched_length) begin
				$error("matched_length: expected %0d, got %0d",
					want.matched_length, got.matched_length);
				errors++;
			end
			if (got.overrun !== want.overrun) begin
				$error("overrun: expected %0d, got %0d", want.overrun, got.overrun);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       op = '0;
	logic [POS_W-1:0] table_address = '0;
	logic [7:0]       byte_value = '0;
	logic             key_first = 1'b0;
	logic [1:0]       search_mode = '0;
	logic [POS_W-1:0] start_position = '0;
	logic             busy, done, found, overrun;
	logic [POS_W-1:0] partner_position, next_start;
	logic [LEN_W-1:0] matched_length;

	lookup_scoreboard sb;
	bit gaps_on = 1'b1;
	int request_count = 0;
	int stall_cycles = 0;

	// record image under construction, with the strings of each record
	logic [7:0] img[$];
	int rec_at[$];
	string first_txt[$];
	string second_txt[$];

	string_pair_table_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.table_address(table_address),
		.byte_value(byte_value),
		.key_first(key_first),
		.search_mode(search_mode),
		.start_position(start_position),
		.done(done),
		.found(found),
		.partner_position(partner_position),
		.next_start(next_start),
		.matched_length(matched_length),
		.overrun(overrun)
	);

	always #5 clk = ~clk;

	// check each result strobe against the oldest pending search
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result({found, partner_position, next_start, matched_length, overrun});
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic request_t random_request();
		request_t rq;
		rq.op = 2'($urandom);
		rq.addr = POS_W'($urandom);
		rq.val = 8'($urandom);
		rq.first = 1'($urandom);
		rq.mode = 2'($urandom);
		rq.spos = POS_W'($urandom);
		return rq;
	endfunction

	// present one request, hold it until accepted, then note it
	task automatic send(request_t rq);
		while (gaps_on && $urandom_range(0, 99) < 13) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= rq.op;
		table_address <= rq.addr;
		byte_value <= rq.val;
		key_first <= rq.first;
		search_mode <= rq.mode;
		start_position <= rq.spos;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(rq);
		if (!(rq.op == OP_UNUSED || (rq.op == OP_SEARCH && rq.mode == MODE_UNUSED)))
			request_count++;
	endtask

	task automatic put_byte(int addr, logic [7:0] val);
		request_t rq;
		rq = random_request();
		rq.op = OP_TABLE_WRITE;
		rq.addr = POS_W'(addr);
		rq.val = val;
		send(rq);
	endtask

	task automatic append_key(logic [7:0] val, logic first);
		request_t rq;
		rq = random_request();
		rq.op = OP_KEY_APPEND;
		rq.val = val;
		rq.first = first;
		send(rq);
	endtask

	task automatic run_search(logic [1:0] mode, int spos);
		request_t rq;
		rq = random_request();
		rq.op = OP_SEARCH;
		rq.mode = mode;
		rq.spos = POS_W'(spos);
		send(rq);
	endtask

	// load a whole key; an empty key is a zero byte with the clear flag
	task automatic set_key(string s);
		int i;
		if (s.len() == 0)
			append_key(8'd0, 1'b1);
		for (i = 0; i < s.len(); i++)
			append_key(s[i], i == 0);
	endtask

	function automatic string rand_text(int lo, int hi);
		string s;
		int n, i;
		s = "";
		n = $urandom_range(hi, lo);
		// small alphabet so strings collide and share prefixes
		for (i = 0; i < n; i++)
			s = $sformatf("%s%c", s, CHAR_A + 8'($urandom_range(0, 2)));
		return s;
	endfunction

	// keep, shorten, extend or spoil a table string to make a key
	function automatic string shape_key(string s);
		string k;
		k = s;
		case ($urandom_range(0, 3))
			0: ;
			1: k = s.substr(0, s.len() - 2);
			2: k = {s, rand_text(1, 3)};
			default: begin
				if (s.len() > 0)
					k[$urandom_range(0, s.len() - 1)] = CHAR_A + 8'd3;
			end
		endcase
		return k;
	endfunction

	function automatic void add_record(string a, string b, int pad);
		int span, i;
		span = a.len() + b.len() + 3 + pad;
		rec_at.push_back(img.size());
		first_txt.push_back(a);
		second_txt.push_back(b);
		img.push_back(span > 255 ? 8'd255 : 8'(span));
		for (i = 0; i < a.len(); i++)
			img.push_back(a[i]);
		img.push_back(8'd0);
		for (i = 0; i < b.len(); i++)
			img.push_back(b[i]);
		img.push_back(8'd0);
		repeat (pad) img.push_back(8'($urandom));
	endfunction

	function automatic void clear_image();
		img.delete();
		rec_at.delete();
		first_txt.delete();
		second_txt.delete();
	endfunction

	// write the image plus an end marker; drop bytes past the table end
	task automatic commit_image(int base);
		int k;
		img.push_back(8'd0);
		for (k = 0; k < img.size() && base + k < TBL_SIZE; k++)
			put_byte(base + k, img[k]);
	endtask

	initial begin
		request_t rq;
		int rand_floor, phase, base, k, pick, hops, a;
		logic [1:0] mode;
		string txt;

		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every table byte gets written before any search reads it
		for (a = 0; a < TBL_SIZE; a++)
			put_byte(a, 8'd0);

		// prefix chain, padding and an empty first string at the table start
		clear_image();
		add_record("ab", "xy", 0);
		add_record("a", "q", 2);
		add_record("", "e", 0);
		add_record("abc", "zz", 1);
		commit_image(0);
		set_key("ab");
		run_search(MODE_EXACT, 0);
		run_search(MODE_PREFIX, rec_at[1]);
		run_search(MODE_EXACT, rec_at[1]);
		set_key("xyw");
		run_search(MODE_INVERSE, 0);
		run_search(MODE_UNUSED, 0);
		rq = random_request();
		rq.op = OP_UNUSED;
		send(rq);
		// zero key bytes: clear without storing, then no effect on a key
		append_key(8'd0, 1'b1);
		run_search(MODE_EXACT, 0);
		run_search(MODE_PREFIX, 0);
		set_key("abcd");
		append_key(8'd0, 1'b0);
		run_search(MODE_PREFIX, rec_at[3]);

		// table end: wrapped resume position, then overrun on the next hop
		clear_image();
		add_record("ab", "cd", 34);
		commit_image(TBL_SIZE - 12);
		set_key("ab");
		run_search(MODE_EXACT, TBL_SIZE - 12);
		set_key("zz");
		run_search(MODE_EXACT, TBL_SIZE - 12);
		// first string cut off by the table end
		clear_image();
		add_record("abcd", "x", 0);
		commit_image(TBL_SIZE - 3);
		set_key("abcd");
		run_search(MODE_EXACT, TBL_SIZE - 3);
		run_search(MODE_INVERSE, TBL_SIZE - 3);
		// partner string would start just past the end
		clear_image();
		add_record("ab", "x", 0);
		commit_image(TBL_SIZE - 4);
		set_key("ab");
		run_search(MODE_EXACT, TBL_SIZE - 4);
		run_search(MODE_INVERSE, TBL_SIZE - 4);

		// random record chains with keys taken from their strings
		rand_floor = request_count;
		phase = 0;
		while (request_count - rand_floor < RANDOM_ITEMS) begin
			gaps_on = !(phase >= 4 && phase < 8);
			clear_image();
			if (phase % 10 == 6) begin
				// long first string against a key that can overflow its buffer
				base = $urandom_range(0, TBL_SIZE - 300);
				txt = rand_text(200, 255);
				add_record(txt, rand_text(0, 3), 0);
				commit_image(base);
				set_key({txt, rand_text(0, 40)});
				run_search(MODE_EXACT, base);
				run_search(MODE_PREFIX, base);
				run_search(MODE_INVERSE, base);
				append_key(CHAR_A, 1'b0);
				run_search(MODE_PREFIX, base);
			end else begin
				if ($urandom_range(0, 9) == 0)
					base = TBL_SIZE - int'($urandom_range(1, 48));
				else
					base = $urandom_range(0, TBL_SIZE - 200);
				repeat ($urandom_range(1, 5))
					add_record(rand_text(0, 5), rand_text(0, 5),
						($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
				commit_image(base);
				repeat ($urandom_range(3, 10)) begin
					pick = $urandom_range(0, 99);
					if (pick < 60) begin
						k = $urandom_range(0, rec_at.size() - 1);
						mode = 2'($urandom_range(0, 2));
						txt = (mode == MODE_INVERSE) ? second_txt[k] : first_txt[k];
						set_key(shape_key(txt));
						run_search(mode, base + rec_at[$urandom_range(0, k)]);
						// follow resume positions to further matches
						hops = 0;
						while (sb.last_prediction.found && hops < 3) begin
							run_search(mode, int'(sb.last_prediction.next_start));
							hops++;
						end
					end else if (pick < 70) begin
						run_search(2'($urandom), $urandom_range(0, TBL_SIZE - 1));
					end else if (pick < 80) begin
						put_byte($urandom_range(0, TBL_SIZE - 1), 8'($urandom));
					end else if (pick < 90) begin
						append_key(8'($urandom), 1'($urandom));
					end else begin
						rq = random_request();
						rq.op = OP_UNUSED;
						send(rq);
					end
				end
			end
			phase++;
		end
		start <= 1'b0;

		// drain pending results, then watch for strays
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d requests: %0d searches, %0d found, %0d overrun",
			request_count, sb.searches, sb.hits, sb.overruns);
		$display("key bytes dropped at full buffer: %0d, mismatches: %0d",
			sb.key_drops, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
